// File: rtl/core/arm_alu_pkg.sv
// ----------------------------------------------------------------------------
// ARM add/subtract ALU package
// Shared constants and types for the add/subtract ALU with condition flags.
// ----------------------------------------------------------------------------
package arm_alu_pkg;

  // Register file geometry. Entry 15 is the program counter.
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] PC_INDEX = 4'd15;

  // Operation codes.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_ADC = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_SBC = 3'd3;
  localparam logic [2:0] OP_RSB = 3'd4;
  localparam logic [2:0] OP_RSC = 3'd5;

  // Positions of the condition flags in a status word.
  localparam int unsigned N_BIT = 31;
  localparam int unsigned V_BIT = 28;

  localparam logic [DATA_W-1:0] PC_STEP = 32'd4;

  // Condition flags, in status word order.
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // Result of one ALU operation.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] result;
    flags_t            flags;
  } alu_res_t;

endpackage

// File: rtl/core/arm_alu_if.sv
// ----------------------------------------------------------------------------
// ARM add/subtract ALU channels
// Request channel (one instruction) and response channel (result and state).
// ----------------------------------------------------------------------------
interface arm_alu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic        set_flags;
  logic [3:0]  dest_index;
  logic [3:0]  src_index;
  logic [31:0] operand_b;

  modport source (
    output valid, req_type, set_flags, dest_index, src_index, operand_b,
    input  ready
  );
  modport sink (
    input  valid, req_type, set_flags, dest_index, src_index, operand_b,
    output ready
  );
endinterface

interface arm_alu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic [31:0] next_pc;

  modport source (
    output valid, result_value, flag_n, flag_z, flag_c, flag_v, next_pc,
    input  ready
  );
  modport sink (
    input  valid, result_value, flag_n, flag_z, flag_c, flag_v, next_pc,
    output ready
  );
endinterface

// File: rtl/core/arm_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// ARM add/subtract ALU with flags
// Top level: register file RAM, forwarding, execute stage and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one ADD/ADC/SUB/SBC/RSB/RSC instruction per
//   request. The rsp channel returns the value written to Rd, the N/Z/C/V
//   flags and the program counter after that instruction, one response per
//   request and in order. saved_status is written through cfg_we/cfg_wdata
//   only while no instruction is in flight; the user must keep to this, as
//   the block does not enforce it. One request is taken every cycle while
//   the receiver does not stall; the rate is set by the single register
//   file read port, read as the request is taken, ahead of execution, with
//   the write of the previous instruction forwarded around the RAM.
//   Reset clears the valid bits of registers 0 to 14 (so they read as zero),
//   the program counter, the flags and saved_status. No clearing pass.
//   When the receiver stalls, the response register holds and the execute
//   stage holds its instruction. req.ready is low in every stalled cycle in
//   which the execute stage is occupied, so it falls in the same cycle when
//   the stage is already full and one request later when it is empty.
// ----------------------------------------------------------------------------
module arm_add_sub_alu_with_flags
  import arm_alu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  arm_alu_req_if.sink          req,
  arm_alu_rsp_if.source        rsp,
  input  logic                 cfg_we,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  // Execute stage registers.
  logic                 s1_valid;
  logic [2:0]           s1_op;
  logic                 s1_s;
  logic [REG_IDX_W-1:0] s1_rd;
  logic [REG_IDX_W-1:0] s1_rn;
  logic [DATA_W-1:0]    s1_shop;
  logic                 byp_hit;
  logic [DATA_W-1:0]    byp_data;

  // Architectural state held in flip-flops.
  logic [DATA_W-1:0]    pc;
  logic [DATA_W-1:0]    pc_next;
  flags_t               flags;
  flags_t               flags_next;
  flags_t               saved_flags;
  logic [REG_COUNT-1:0] reg_valid;

  // Response register.
  logic                 out_valid;
  logic [DATA_W-1:0]    out_result;
  flags_t               out_flags;
  logic [DATA_W-1:0]    out_pc;

  logic                 accept;
  logic                 s1_go;
  logic                 ram_we;
  logic [DATA_W-1:0]    ram_q;
  logic [DATA_W-1:0]    rn_value;
  alu_res_t             alu_res;

  // Handshake: the execute stage moves when the response register frees up.
  assign s1_go     = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;
  assign accept    = req.valid && req.ready;

  // Register file for entries 0 to 14; the program counter lives in pc.
  assign ram_we = s1_go && alu_res.valid && (s1_rd != PC_INDEX);

  arm_alu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_rd),
    .wdata (alu_res.result),
    .re    (accept),
    .raddr (req.src_index),
    .rdata (ram_q)
  );

  // Rn select: program counter, forwarded write, RAM, or reset value.
  always_comb begin
    priority if (s1_rn == PC_INDEX) begin
      rn_value = pc;
    end else if (byp_hit) begin
      rn_value = byp_data;
    end else if (reg_valid[s1_rn]) begin
      rn_value = ram_q;
    end else begin
      rn_value = '0;
    end
  end

  arm_alu_exec u_exec (
    .op        (s1_op),
    .rn_value  (rn_value),
    .operand_b (s1_shop),
    .carry_in  (flags.c),
    .res       (alu_res)
  );

  // Next flags and program counter.
  always_comb begin
    flags_next = flags;
    if (alu_res.valid && s1_s) begin
      if (s1_rd == PC_INDEX) begin
        flags_next = saved_flags;
      end else begin
        flags_next = alu_res.flags;
      end
    end
    if (alu_res.valid && (s1_rd == PC_INDEX)) begin
      pc_next = alu_res.result;
    end else begin
      pc_next = pc + PC_STEP;
    end
  end

  // Execute stage capture, with forwarding of the write done in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (accept) begin
      s1_op    <= req.req_type;
      s1_s     <= req.set_flags;
      s1_rd    <= req.dest_index;
      s1_rn    <= req.src_index;
      s1_shop  <= req.operand_b;
      byp_hit  <= ram_we && (s1_rd == req.src_index);
      byp_data <= alu_res.result;
    end
  end

  // State update when an instruction retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      flags     <= '0;
      reg_valid <= '0;
    end else if (s1_go) begin
      pc    <= pc_next;
      flags <= flags_next;
      if (ram_we) begin
        reg_valid[s1_rd] <= 1'b1;
      end
    end
  end

  // Saved status register; only the flag bits are ever visible.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_flags <= '0;
    end else if (cfg_we) begin
      saved_flags <= flags_t'(cfg_wdata[N_BIT:V_BIT]);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go) begin
      out_result <= alu_res.valid ? alu_res.result : '0;
      out_flags  <= flags_next;
      out_pc     <= pc_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_result;
  assign rsp.flag_n       = out_flags.n;
  assign rsp.flag_z       = out_flags.z;
  assign rsp.flag_c       = out_flags.c;
  assign rsp.flag_v       = out_flags.v;
  assign rsp.next_pc      = out_pc;

endmodule

// File: rtl/core/arm_alu_ram.sv
// ----------------------------------------------------------------------------
// ARM ALU generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module arm_alu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; a read of the same address in the same cycle returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/arm_alu_exec.sv
// ----------------------------------------------------------------------------
// ARM ALU execute unit
// Operand selection, 33-bit add with carry in, and N/Z/C/V generation.
// ----------------------------------------------------------------------------
module arm_alu_exec
  import arm_alu_pkg::*;
(
  input  logic [2:0]        op,
  input  logic [DATA_W-1:0] rn_value,
  input  logic [DATA_W-1:0] operand_b,
  input  logic              carry_in,
  output alu_res_t          res
);

  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic              cin;
  logic              op_ok;
  logic [DATA_W:0]   sum;

  // Pick operands: subtraction is done as a + ~b + carry.
  always_comb begin
    opa   = '0;
    opb   = '0;
    cin   = 1'b0;
    op_ok = 1'b1;
    unique case (op)
      OP_ADD: begin
        opa = rn_value;  opb = operand_b;  cin = 1'b0;
      end
      OP_ADC: begin
        opa = rn_value;  opb = operand_b;  cin = carry_in;
      end
      OP_SUB: begin
        opa = rn_value;  opb = ~operand_b; cin = 1'b1;
      end
      OP_SBC: begin
        opa = rn_value;  opb = ~operand_b; cin = carry_in;
      end
      OP_RSB: begin
        opa = operand_b; opb = ~rn_value;  cin = 1'b1;
      end
      OP_RSC: begin
        opa = operand_b; opb = ~rn_value;  cin = carry_in;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, opa} + {1'b0, opb} + {{DATA_W{1'b0}}, cin};

  // Result and the flags it would set.
  always_comb begin
    res.valid   = op_ok;
    res.result  = sum[DATA_W-1:0];
    res.flags.n = sum[DATA_W-1];
    res.flags.z = (sum[DATA_W-1:0] == '0);
    res.flags.c = sum[DATA_W];
    res.flags.v = (opa[DATA_W-1] ^ sum[DATA_W-1]) & (opb[DATA_W-1] ^ sum[DATA_W-1]);
  end

endmodule
